### src/hvte_pkg.sv
// Shared item types, character codes and tag pattern helpers for the visible text extractor.
package hvte_pkg;

	// One input item: an HTML byte and its end-of-text mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	// One result item: a visible character, its valid bit and the end-of-text mark.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_of_text;
	} out_item_t;

	// Number of leading window bytes that the tag patterns can reach.
	localparam int PAT_BYTES = 8;

	// Tag patterns, first character in the most significant used byte.
	localparam logic [63:0] PAT_SCRIPT_OPEN  = 64'("<script");
	localparam int          PAT_SCRIPT_OPEN_LEN  = 7;
	localparam logic [63:0] PAT_SCRIPT_CLOSE = 64'("</script");
	localparam int          PAT_SCRIPT_CLOSE_LEN = 8;
	localparam logic [63:0] PAT_STYLE_OPEN   = 64'("<style");
	localparam int          PAT_STYLE_OPEN_LEN   = 6;
	localparam logic [63:0] PAT_STYLE_CLOSE  = 64'("</style");
	localparam int          PAT_STYLE_CLOSE_LEN  = 7;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Reset value of the character limit.
	localparam logic [15:0] MAX_CHARS_RESET = 16'd2047;

	// Folds ASCII upper case letters to lower case.
	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

	// Compares the first len window bytes (byte k at bits 8k) with a pattern.
	function automatic logic pat_hit(input logic [63:0] w8, input logic [63:0] pat,
			input int len);
		logic hit;
		hit = 1'b1;
		for (int k = 0; k < PAT_BYTES; k++) begin
			if (k < len) begin
				if (lower_ascii(w8[8*k +: 8]) != pat[8*(len-1-k) +: 8]) begin
					hit = 1'b0;
				end
			end
		end
		return hit;
	endfunction

endpackage

### src/html_visible_text_extractor.sv
// Visible text extractor: strips tags, script and style sections from an HTML byte stream.
//
// Usage: HTML bytes enter on the byte channel (byte_valid/byte_ready/byte_item), one item per
// byte. Visible characters leave on the text channel (text_valid/text_ready/text_item).
// The character limit is written on the cfg channel (cfg_valid/cfg_ready/cfg_data), which is
// always ready; write it only while the block is idle.
// Bytes pass an input register, then a lookahead window of LOOKAHEAD bytes; a byte is judged
// when it leaves the window, so characters appear LOOKAHEAD-1 items after their byte.
// Throughput is one byte per cycle while the result register is free and no flush is running:
// the pattern compare and the judge of the oldest window byte sit in one stage between the
// input register and the result register. A zero byte or a set final_byte ends the text.
// The window is then flushed one byte per cycle while the result register is free, through
// the same judge logic, and no further item is processed meanwhile. The last result of a
// text carries end_of_text; a text with no visible character yields one empty result with
// end_of_text. An item that causes a result directly goes from the input register straight
// into the result register. When a result waits and text_ready is low, the result register
// holds and the pipeline stalls; one more item can still be taken into the input register.
// Reset clears the window, all text state and sets the character limit to 2047.
module html_visible_text_extractor
	import hvte_pkg::*;
#(
	parameter int LOOKAHEAD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  in_item_t    byte_item,
	output logic        text_valid,
	input  logic        text_ready,
	output out_item_t   text_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int FW = $clog2(LOOKAHEAD + 1);

	// Registers.
	logic            vld_s1;
	in_item_t        item_s1;
	logic [7:0]      win_q [LOOKAHEAD];
	logic [FW-1:0]   fill_q;
	logic            in_tag_q;
	logic            skip_script_q;
	logic            skip_style_q;
	logic            last_space_q;
	logic [15:0]     count_q;
	logic            stopped_q;
	logic [15:0]     max_chars_q;
	logic            flushing_q;
	logic            pend_valid_q;
	logic [7:0]      pend_q;
	logic            out_valid_q;
	out_item_t       out_q;

	// Combinational signals.
	logic            out_free;
	logic            take_s1;
	logic            ending;
	logic            app;
	logic [FW-1:0]   fa;
	logic [7:0]      wa [LOOKAHEAD];
	logic [7:0]      jw [LOOKAHEAD];
	logic [7:0]      ws [LOOKAHEAD];
	logic [FW-1:0]   jf;
	logic [63:0]     jw8;
	logic            norm_judge;
	logic            flush_judge;
	logic            flush_end;
	logic            j_emit;
	logic [7:0]      j_char;
	logic            j_in_tag;
	logic            j_skip_script;
	logic            j_skip_style;
	logic            j_last_space;
	logic [15:0]     j_count;
	logic            j_stopped;
	logic            push;
	out_item_t       push_item;

	// Handshake and step control.
	assign out_free   = !out_valid_q || text_ready;
	assign take_s1    = vld_s1 && !flushing_q && out_free;
	assign byte_ready = !vld_s1 || take_s1;
	assign cfg_ready  = 1'b1;
	assign text_valid = out_valid_q;
	assign text_item  = out_q;

	// Append the held byte to the window and choose which window the judge looks at.
	always_comb begin
		ending      = (item_s1.in_byte == CH_NUL) || item_s1.final_byte;
		app         = take_s1 && (item_s1.in_byte != CH_NUL) && !stopped_q;
		fa          = fill_q + FW'(app);
		for (int i = 0; i < LOOKAHEAD; i++) begin
			wa[i] = (app && fill_q == FW'(i)) ? item_s1.in_byte : win_q[i];
		end
		norm_judge  = take_s1 && !ending && app && (fa == FW'(LOOKAHEAD));
		flush_judge = flushing_q && out_free && (fill_q != '0);
		flush_end   = flushing_q && out_free && (fill_q == '0);
		for (int i = 0; i < LOOKAHEAD; i++) begin
			jw[i] = flushing_q ? win_q[i] : wa[i];
		end
		jf = flushing_q ? fill_q : fa;
		for (int i = 0; i < LOOKAHEAD - 1; i++) begin
			ws[i] = jw[i+1];
		end
		ws[LOOKAHEAD-1] = CH_NUL;
		for (int k = 0; k < PAT_BYTES; k++) begin
			jw8[8*k +: 8] = jw[k];
		end
	end

	// Judge the oldest window byte.
	always_comb begin
		logic [7:0] c;
		logic       hidden;
		logic       m_so;
		logic       m_sc;
		logic       m_yo;
		logic       m_yc;
		j_emit        = 1'b0;
		j_char        = CH_NUL;
		j_in_tag      = in_tag_q;
		j_skip_script = skip_script_q;
		j_skip_style  = skip_style_q;
		j_last_space  = last_space_q;
		j_count       = count_q;
		j_stopped     = stopped_q;
		c      = jw[0];
		hidden = in_tag_q || skip_script_q || skip_style_q;
		m_so   = (jf >= FW'(PAT_SCRIPT_OPEN_LEN))
			&& pat_hit(jw8, PAT_SCRIPT_OPEN, PAT_SCRIPT_OPEN_LEN);
		m_sc   = (jf >= FW'(PAT_SCRIPT_CLOSE_LEN))
			&& pat_hit(jw8, PAT_SCRIPT_CLOSE, PAT_SCRIPT_CLOSE_LEN);
		m_yo   = (jf >= FW'(PAT_STYLE_OPEN_LEN))
			&& pat_hit(jw8, PAT_STYLE_OPEN, PAT_STYLE_OPEN_LEN);
		m_yc   = (jf >= FW'(PAT_STYLE_CLOSE_LEN))
			&& pat_hit(jw8, PAT_STYLE_CLOSE, PAT_STYLE_CLOSE_LEN);
		if (c == CH_CR || c == CH_LF || c == CH_TAB) begin
			c = CH_SPACE;
		end
		priority if (stopped_q || count_q >= max_chars_q) begin
			j_stopped = 1'b1;
		end else if (m_so) begin
			j_skip_script = 1'b1;
			j_in_tag      = 1'b1;
		end else if (m_sc) begin
			j_skip_script = 1'b0;
			j_in_tag      = 1'b1;
		end else if (m_yo) begin
			j_skip_style = 1'b1;
			j_in_tag     = 1'b1;
		end else if (m_yc) begin
			j_skip_style = 1'b0;
			j_in_tag     = 1'b1;
		end else if (jw[0] == CH_LT) begin
			j_in_tag = 1'b1;
			if (!last_space_q) begin
				j_last_space = 1'b1;
				j_emit       = 1'b1;
				j_char       = CH_SPACE;
			end
		end else if (jw[0] == CH_GT) begin
			j_in_tag = 1'b0;
		end else if (hidden || c < CH_SPACE) begin
			// Hidden text and control bytes are dropped.
		end else if (c == CH_SPACE) begin
			if (!last_space_q) begin
				j_last_space = 1'b1;
				j_emit       = 1'b1;
				j_char       = CH_SPACE;
			end
		end else begin
			j_last_space = 1'b0;
			j_emit       = 1'b1;
			j_char       = c;
		end
		// Count the character and stop at the limit.
		if (j_emit) begin
			j_count = count_q + 16'd1;
			if (j_count >= max_chars_q) begin
				j_stopped = 1'b1;
			end
		end
	end

	// Choose the result that enters the result register.
	always_comb begin
		push      = 1'b0;
		push_item = '{out_char: CH_NUL, char_valid: 1'b0, end_of_text: 1'b0};
		priority if (norm_judge && j_emit) begin
			push      = 1'b1;
			push_item = '{out_char: j_char, char_valid: 1'b1, end_of_text: 1'b0};
		end else if (flush_judge && j_emit && pend_valid_q) begin
			push      = 1'b1;
			push_item = '{out_char: pend_q, char_valid: 1'b1, end_of_text: 1'b0};
		end else if (flush_end) begin
			push      = 1'b1;
			push_item = pend_valid_q
				? '{out_char: pend_q, char_valid: 1'b1, end_of_text: 1'b1}
				: '{out_char: CH_NUL, char_valid: 1'b0, end_of_text: 1'b1};
		end else begin
			push = 1'b0;
		end
	end

	// Control state and text state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			fill_q        <= '0;
			in_tag_q      <= 1'b0;
			skip_script_q <= 1'b0;
			skip_style_q  <= 1'b0;
			last_space_q  <= 1'b1;
			count_q       <= '0;
			stopped_q     <= 1'b0;
			max_chars_q   <= MAX_CHARS_RESET;
			flushing_q    <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_chars_q <= cfg_data;
			end
			if (byte_valid && byte_ready) begin
				vld_s1 <= 1'b1;
			end else if (take_s1) begin
				vld_s1 <= 1'b0;
			end
			// Judge results update the text state.
			if (norm_judge || flush_judge) begin
				in_tag_q      <= j_in_tag;
				skip_script_q <= j_skip_script;
				skip_style_q  <= j_skip_style;
				last_space_q  <= j_last_space;
				count_q       <= j_count;
				stopped_q     <= j_stopped;
			end
			if (take_s1) begin
				if (ending) begin
					fill_q     <= fa;
					flushing_q <= 1'b1;
				end else if (norm_judge) begin
					fill_q <= FW'(LOOKAHEAD - 1);
				end else begin
					fill_q <= fa;
				end
			end
			if (flush_judge) begin
				fill_q <= fill_q - FW'(1);
				if (j_emit) begin
					pend_valid_q <= 1'b1;
				end
			end
			// End of text returns the text state to its reset value.
			if (flush_end) begin
				fill_q        <= '0;
				in_tag_q      <= 1'b0;
				skip_script_q <= 1'b0;
				skip_style_q  <= 1'b0;
				last_space_q  <= 1'b1;
				count_q       <= '0;
				stopped_q     <= 1'b0;
				flushing_q    <= 1'b0;
				pend_valid_q  <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= push;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
		if (take_s1) begin
			for (int i = 0; i < LOOKAHEAD; i++) begin
				win_q[i] <= norm_judge ? ws[i] : wa[i];
			end
		end
		if (flush_judge) begin
			win_q <= ws;
			if (j_emit) begin
				pend_q <= j_char;
			end
		end
		if (out_free && push) begin
			out_q <= push_item;
		end
	end

	// A held character only exists while the window is being flushed.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> flushing_q)
		else $error("held character outside a flush");

	// Outside a flush the window never stays full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!flushing_q |-> fill_q < FW'(LOOKAHEAD))
		else $error("window full outside a flush");

	// The end of a flush always delivers the end-of-text result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flushing_q) |-> (text_valid && text_item.end_of_text))
		else $error("flush ended without an end-of-text result");

	// An empty result is only ever the end-of-text marker.
	assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text_item.char_valid) |-> text_item.end_of_text)
		else $error("empty result without end of text");

endmodule
